@@ rtl/masked_block_topk_select_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the top-k block selector
// Shorthand for clocked implications, gated by reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_BLOCK_TOPK_SELECT_CORE_ASSERT_SVH
`define MASKED_BLOCK_TOPK_SELECT_CORE_ASSERT_SVH

// same-cycle implication
`define MTK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MTK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/mtk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtk_pkg
// Types, constants and score helpers for the top-k block selector.
// ----------------------------------------------------------------------------
package mtk_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int ID_W       = 9;
    localparam int SCORE_W    = 32;
    localparam int QPOS_W     = 24;
    localparam int BSIZE_W    = 16;
    localparam int KSEL_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_BLOCKS  = 3'd0,
        CFG_K_SELECT    = 3'd1,
        CFG_BLOCK_SIZE  = 3'd2,
        CFG_CAUSAL      = 3'd3,
        CFG_FORCE_LOCAL = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIRST,
        ST_EMIT
    } st_t;

    typedef struct packed {
        logic               valid;
        logic               used;
        logic [SCORE_W-1:0] key;
        logic [ID_W-1:0]    id;
    } cell_t;

    typedef struct packed {
        logic ins;
        logic rot;
        logic clr;
    } cell_ctl_t;

    // map a float32 pattern to an unsigned key with the same order; -0 folds to +0
    function automatic logic [SCORE_W-1:0] score_key(input logic [SCORE_W-1:0] bits);
        logic [SCORE_W-1:0] k;
        if (bits[SCORE_W-2:0] == '0) begin
            k = {1'b1, {(SCORE_W-1){1'b0}}};
        end else if (bits[SCORE_W-1]) begin
            k = ~bits;
        end else begin
            k = {1'b1, bits[SCORE_W-2:0]};
        end
        return k;
    endfunction

    function automatic logic is_nan(input logic [SCORE_W-1:0] bits);
        return (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
    endfunction

endpackage

@@ rtl/mtk_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtk_div
// Restoring divider, one quotient bit per cycle, for the local block index.
// ----------------------------------------------------------------------------
module mtk_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [mtk_pkg::QPOS_W-1:0]       dividend,
    input  logic [mtk_pkg::BSIZE_W-1:0]      divisor,
    output logic                             done,
    output logic [mtk_pkg::QPOS_W-1:0]       quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [mtk_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [mtk_pkg::BSIZE_W:0]       rem_reg, rem_next;
    logic [mtk_pkg::QPOS_W-1:0]      quo_reg, quo_next;
    logic [mtk_pkg::BSIZE_W-1:0]     dsr_reg, dsr_next;
    logic [mtk_pkg::BSIZE_W:0]       rem_sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg[mtk_pkg::BSIZE_W-1:0], quo_reg[mtk_pkg::QPOS_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next = rem_sh - {1'b0, dsr_reg};
                quo_next = {quo_reg[mtk_pkg::QPOS_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[mtk_pkg::QPOS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mtk_pkg::DIV_CNT_W'(mtk_pkg::QPOS_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/mtk_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtk_cell
// One slot of the sorted insertion chain: compare, hold, shift, rotate or clear.
// ----------------------------------------------------------------------------
module mtk_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mtk_pkg::cell_ctl_t            ctl,
    input  logic [mtk_pkg::SCORE_W-1:0]   ins_key,
    input  logic [mtk_pkg::ID_W-1:0]      ins_id,
    input  logic                          prev_keep,
    input  mtk_pkg::cell_t                prev_cell,
    input  mtk_pkg::cell_t                rot_cell,
    input  logic [mtk_pkg::ID_W-1:0]      probe_id,
    output logic                          keep,
    output logic                          hit,
    output mtk_pkg::cell_t                entry
);

    mtk_pkg::cell_t cell_reg, cell_next;

    assign keep  = cell_reg.valid && (cell_reg.key >= ins_key);
    assign hit   = cell_reg.valid && cell_reg.used && (cell_reg.id == probe_id);
    assign entry = cell_reg;

    always_comb begin
        cell_next = cell_reg;
        if (ctl.clr) begin
            cell_next = '0;
        end else if (ctl.rot) begin
            cell_next = rot_cell;
        end else if (ctl.ins && !keep) begin
            if (prev_keep) begin
                cell_next.valid = 1'b1;
                cell_next.used  = 1'b0;
                cell_next.key   = ins_key;
                cell_next.id    = ins_id;
            end else begin
                cell_next = prev_cell;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else begin
            cell_reg <= cell_next;
        end
    end

endmodule

@@ rtl/masked_block_topk_select_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_block_topk_select_core
// Streaming top-k block selector for one sparse-attention score row at a time.
// ----------------------------------------------------------------------------
// Scores enter a chain of MAX_K cells kept sorted by score, then by lower id.
// Within a row one score is taken per cycle. The first score of a row is held
// while the bit-serial divider finds the local block, and is then inserted
// (the divider is skipped when block_size is zero).
// After the row's last score, at most one result leaves per cycle that the output
// is free; rotating out a chain entry whose id is out of range, or passing an
// already chosen id in the lowest-unchosen fallback scan, yields no result; no
// input is taken while a row's results are produced.
module masked_block_topk_select_core #(
    parameter int MAX_K = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [mtk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mtk_pkg::QPOS_W-1:0]         s_query_pos,
    input  logic [mtk_pkg::SCORE_W-1:0]        s_score_bits,
    input  logic                               s_row_end,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mtk_pkg::ID_W-1:0]           m_block_id,
    output logic                               m_filler,
    output logic                               m_last_of_row
);

    localparam int K_W  = $clog2(MAX_K + 1);
    localparam int KX_W = (K_W > mtk_pkg::KSEL_W) ? K_W : mtk_pkg::KSEL_W;
    localparam int ID_W = mtk_pkg::ID_W;

    logic [ID_W-1:0]                 cfg_nb_reg;
    logic [mtk_pkg::KSEL_W-1:0]      cfg_k_reg;
    logic [mtk_pkg::BSIZE_W-1:0]     cfg_bs_reg;
    logic                            cfg_causal_reg;
    logic                            cfg_force_reg;

    mtk_pkg::st_t                    state_reg, state_next;
    logic                            row_started_reg, row_started_next;
    logic [ID_W-1:0]                 local_reg, local_next;
    logic [ID_W-1:0]                 counter_reg, counter_next;
    logic [K_W-1:0]                  cnt_reg, cnt_next;
    logic [K_W-1:0]                  popped_reg, popped_next;
    logic [KX_W-1:0]                 k_reg, k_next;
    logic [KX_W-1:0]                 slot_reg, slot_next;
    logic [ID_W-1:0]                 scan_reg, scan_next;
    logic                            local_taken_reg, local_taken_next;
    logic [mtk_pkg::SCORE_W-1:0]     hold_bits_reg, hold_bits_next;
    logic                            hold_end_reg, hold_end_next;

    logic                            m_valid_reg, m_valid_next;
    logic [ID_W-1:0]                 m_id_reg, m_id_next;
    logic                            m_fill_reg, m_fill_next;
    logic                            m_last_reg, m_last_next;

    logic [ID_W-1:0]                 nb, nb_m1;
    logic [KX_W-1:0]                 k_eff;
    logic                            div_start, div_done;
    logic [mtk_pkg::QPOS_W-1:0]      div_q;
    logic                            ins_req, ins_end;
    logic [mtk_pkg::SCORE_W-1:0]     ins_bits;
    logic                            emit;
    logic [ID_W-1:0]                 emit_id;
    logic                            emit_fill;
    logic                            rot_mark;
    logic                            chosen;
    logic                            out_free;
    mtk_pkg::cell_ctl_t              ctl;
    mtk_pkg::cell_t                  cells [MAX_K];
    mtk_pkg::cell_t                  rot_last;
    logic [MAX_K-1:0]                keeps, hits;

    assign nb = (cfg_nb_reg == '0) ? ID_W'(1) :
                (cfg_nb_reg > ID_W'(mtk_pkg::MAX_BLOCKS)) ? ID_W'(mtk_pkg::MAX_BLOCKS) :
                cfg_nb_reg;
    assign nb_m1 = nb - 1'b1;
    assign k_eff = (KX_W'(cfg_k_reg) > KX_W'(MAX_K)) ? KX_W'(MAX_K) : KX_W'(cfg_k_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_nb_reg     <= ID_W'(256);
            cfg_k_reg      <= mtk_pkg::KSEL_W'(16);
            cfg_bs_reg     <= mtk_pkg::BSIZE_W'(64);
            cfg_causal_reg <= 1'b1;
            cfg_force_reg  <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                mtk_pkg::CFG_NUM_BLOCKS:  cfg_nb_reg     <= cfg_wdata[ID_W-1:0];
                mtk_pkg::CFG_K_SELECT:    cfg_k_reg      <= cfg_wdata[mtk_pkg::KSEL_W-1:0];
                mtk_pkg::CFG_BLOCK_SIZE:  cfg_bs_reg     <= cfg_wdata;
                mtk_pkg::CFG_CAUSAL:      cfg_causal_reg <= cfg_wdata[0];
                mtk_pkg::CFG_FORCE_LOCAL: cfg_force_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    mtk_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_query_pos),
        .divisor  (cfg_bs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rot_last = '{valid: cells[0].valid, used: rot_mark,
                        key: cells[0].key, id: cells[0].id};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_K; gi++) begin : g_chain
            logic           pk;
            mtk_pkg::cell_t pc;
            mtk_pkg::cell_t rc;
            if (gi == 0) begin : g_head
                assign pk = 1'b1;
                assign pc = '0;
            end else begin : g_body
                assign pk = keeps[gi-1];
                assign pc = cells[gi-1];
            end
            if (gi == MAX_K - 1) begin : g_tail
                assign rc = rot_last;
            end else begin : g_mid
                assign rc = cells[gi+1];
            end
            mtk_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .ins_key   (mtk_pkg::score_key(ins_bits)),
                .ins_id    (counter_reg),
                .prev_keep (pk),
                .prev_cell (pc),
                .rot_cell  (rc),
                .probe_id  (scan_reg),
                .keep      (keeps[gi]),
                .hit       (hits[gi]),
                .entry     (cells[gi])
            );
        end
    endgenerate

    assign out_free = !m_valid_reg || m_ready;
    assign chosen   = (local_taken_reg && (scan_reg == local_reg)) || (|hits);
    assign s_ready  = (state_reg == mtk_pkg::ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        row_started_next = row_started_reg;
        local_next       = local_reg;
        counter_next     = counter_reg;
        cnt_next         = cnt_reg;
        popped_next      = popped_reg;
        k_next           = k_reg;
        slot_next        = slot_reg;
        scan_next        = scan_reg;
        local_taken_next = local_taken_reg;
        hold_bits_next   = hold_bits_reg;
        hold_end_next    = hold_end_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_id_next        = m_id_reg;
        m_fill_next      = m_fill_reg;
        m_last_next      = m_last_reg;
        div_start        = 1'b0;
        ins_req          = 1'b0;
        ins_end          = 1'b0;
        ins_bits         = s_score_bits;
        emit             = 1'b0;
        emit_id          = scan_reg;
        emit_fill        = 1'b0;
        rot_mark         = 1'b0;
        ctl              = '0;

        case (state_reg)
            mtk_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (row_started_reg) begin
                        ins_req = 1'b1;
                        ins_end = s_row_end;
                    end else begin
                        hold_bits_next = s_score_bits;
                        hold_end_next  = s_row_end;
                        if (cfg_bs_reg == '0) begin
                            local_next       = nb_m1;
                            row_started_next = 1'b1;
                            counter_next     = '0;
                            state_next       = mtk_pkg::ST_FIRST;
                        end else begin
                            div_start  = 1'b1;
                            state_next = mtk_pkg::ST_DIV;
                        end
                    end
                end
            end
            mtk_pkg::ST_DIV: begin
                if (div_done) begin
                    local_next = (div_q > mtk_pkg::QPOS_W'(nb_m1)) ? nb_m1 : div_q[ID_W-1:0];
                    row_started_next = 1'b1;
                    counter_next     = '0;
                    state_next       = mtk_pkg::ST_FIRST;
                end
            end
            mtk_pkg::ST_FIRST: begin
                ins_req  = 1'b1;
                ins_bits = hold_bits_reg;
                ins_end  = hold_end_reg;
                if (!hold_end_reg) begin
                    state_next = mtk_pkg::ST_IDLE;
                end
            end
            mtk_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (slot_reg == '0 && cfg_force_reg) begin
                        emit             = 1'b1;
                        emit_id          = local_reg;
                        local_taken_next = 1'b1;
                    end else if (popped_reg < cnt_reg) begin
                        ctl.rot     = 1'b1;
                        popped_next = popped_reg + 1'b1;
                        if (cells[0].id < nb) begin
                            emit     = 1'b1;
                            emit_id  = cells[0].id;
                            rot_mark = 1'b1;
                        end
                    end else if (scan_reg < nb && chosen) begin
                        scan_next = scan_reg + 1'b1;
                    end else begin
                        emit      = 1'b1;
                        emit_id   = scan_reg;
                        emit_fill = 1'b1;
                        if (scan_reg < nb) begin
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                    if (emit) begin
                        m_valid_next = 1'b1;
                        m_id_next    = emit_id;
                        m_fill_next  = emit_fill;
                        m_last_next  = (slot_reg + 1'b1 == k_reg);
                        slot_next    = slot_reg + 1'b1;
                        if (slot_reg + 1'b1 == k_reg) begin
                            ctl.clr    = 1'b1;
                            cnt_next   = '0;
                            state_next = mtk_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = mtk_pkg::ST_IDLE;
        endcase

        if (ins_req) begin
            if (counter_reg < nb) begin
                counter_next = counter_reg + 1'b1;
                if (!(cfg_causal_reg && counter_reg > local_reg) &&
                    !(cfg_force_reg && counter_reg == local_reg) &&
                    !mtk_pkg::is_nan(ins_bits)) begin
                    ctl.ins = 1'b1;
                    if (cnt_reg < K_W'(MAX_K)) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            if (ins_end) begin
                row_started_next = 1'b0;
                counter_next     = '0;
                local_next       = (local_reg > nb_m1) ? nb_m1 : local_reg;
                k_next           = k_eff;
                slot_next        = '0;
                popped_next      = '0;
                scan_next        = '0;
                local_taken_next = 1'b0;
                if (k_eff == '0) begin
                    ctl.clr    = 1'b1;
                    ctl.ins    = 1'b0;
                    cnt_next   = '0;
                    state_next = mtk_pkg::ST_IDLE;
                end else begin
                    state_next = mtk_pkg::ST_EMIT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mtk_pkg::ST_IDLE;
            row_started_reg <= 1'b0;
            local_reg       <= '0;
            counter_reg     <= '0;
            cnt_reg         <= '0;
            popped_reg      <= '0;
            k_reg           <= '0;
            slot_reg        <= '0;
            scan_reg        <= '0;
            local_taken_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            row_started_reg <= row_started_next;
            local_reg       <= local_next;
            counter_reg     <= counter_next;
            cnt_reg         <= cnt_next;
            popped_reg      <= popped_next;
            k_reg           <= k_next;
            slot_reg        <= slot_next;
            scan_reg        <= scan_next;
            local_taken_reg <= local_taken_next;
            m_valid_reg     <= m_valid_next;
        end
        hold_bits_reg <= hold_bits_next;
        hold_end_reg  <= hold_end_next;
        m_id_reg   <= m_id_next;
        m_fill_reg <= m_fill_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_block_id    = m_id_reg;
    assign m_filler      = m_fill_reg;
    assign m_last_of_row = m_last_reg;

`include "masked_block_topk_select_core_assert.svh"

    `MTK_ASSERT_NXT(a_out_from_emit, (state_reg != mtk_pkg::ST_EMIT) && !m_valid_reg, !m_valid_reg)
    `MTK_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= K_W'(MAX_K))
    `MTK_ASSERT_IMP(a_pop_bound, state_reg == mtk_pkg::ST_EMIT, popped_reg <= cnt_reg)

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-k block selector testbench
// Streams score rows into the selector under several register settings and
// random handshake pressure on both channels. A local model keeps the sorted
// candidate chain and predicts each selected block id, its filler flag and
// the row's last marker. Each result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int CHAIN_DEPTH = 16;
    localparam logic [31:0] POS_INF  = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF  = 32'hFF80_0000;
    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] ONE      = 32'h3F80_0000;

    typedef struct {
        logic [mtk_pkg::ID_W-1:0] block_id;
        logic                     filler;
        logic                     last;
    } selection_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [mtk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mtk_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [mtk_pkg::QPOS_W-1:0] s_query_pos = '0;
    logic [mtk_pkg::SCORE_W-1:0] s_score_bits = '0;
    logic s_row_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [mtk_pkg::ID_W-1:0] m_block_id;
    logic m_filler;
    logic m_last_of_row;

    masked_block_topk_select_core dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // selector model state
    int unsigned num_blocks_r, k_select_r, block_size_r, causal_r, force_local_r;
    logic [31:0] chain_key [CHAIN_DEPTH];
    int unsigned chain_id [CHAIN_DEPTH];
    int unsigned chain_len;
    int unsigned local_blk, blk_count;
    bit row_open;

    selection_t pending_sel [$];
    int send_gap_pct, recv_stall_pct;
    int mismatches, results_seen, items_sent, rows_sent;

    function automatic int unsigned active_blocks();
        if (num_blocks_r < 1) return 1;
        if (num_blocks_r > mtk_pkg::MAX_BLOCKS) return mtk_pkg::MAX_BLOCKS;
        return num_blocks_r;
    endfunction

    // order-preserving unsigned key; both zeros map to the same key
    function automatic logic [31:0] order_key(logic [31:0] bits);
        if (bits[30:0] == 31'd0) return 32'h8000_0000;
        if (bits[31]) return ~bits;
        return bits | 32'h8000_0000;
    endfunction

    task automatic chain_add(logic [31:0] key, int unsigned id);
        int unsigned p, i;
        p = 0;
        while (p < chain_len && chain_key[p] >= key) p++;
        if (p >= CHAIN_DEPTH) return;
        i = (chain_len < CHAIN_DEPTH) ? chain_len : CHAIN_DEPTH - 1;
        while (i > p) begin
            chain_key[i] = chain_key[i-1];
            chain_id[i] = chain_id[i-1];
            i--;
        end
        chain_key[p] = key;
        chain_id[p] = id;
        if (chain_len < CHAIN_DEPTH) chain_len++;
    endtask

    task automatic predict_selection(logic [23:0] qpos, logic [31:0] bits, logic row_end);
        int unsigned nb, q, k, slot, next, scan, id;
        bit fill, ok;
        bit taken [mtk_pkg::MAX_BLOCKS];
        selection_t sel;
        nb = active_blocks();
        if (!row_open) begin
            q = (block_size_r == 0) ? nb - 1 : qpos / block_size_r;
            local_blk = (q > nb - 1) ? nb - 1 : q;
            chain_len = 0;
            blk_count = 0;
            row_open = 1;
        end
        if (blk_count < nb) begin
            ok = 1;
            if (causal_r != 0 && blk_count > local_blk) ok = 0;
            if (force_local_r != 0 && blk_count == local_blk) ok = 0;
            if (bits[30:23] == 8'hFF && bits[22:0] != 0) ok = 0;
            if (ok) chain_add(order_key(bits), blk_count);
            blk_count++;
        end
        if (!row_end) return;
        row_open = 0;
        blk_count = 0;
        k = (k_select_r > CHAIN_DEPTH) ? CHAIN_DEPTH : k_select_r;
        foreach (taken[i]) taken[i] = 0;
        if (local_blk > nb - 1) local_blk = nb - 1;
        next = 0;
        scan = 0;
        for (slot = 0; slot < k; slot++) begin
            fill = 0;
            if (slot == 0 && force_local_r != 0) begin
                id = local_blk;
            end else begin
                while (next < chain_len && chain_id[next] >= nb) next++;
                if (next < chain_len) begin
                    id = chain_id[next++];
                end else begin
                    while (scan < nb && taken[scan]) scan++;
                    id = scan;
                    fill = 1;
                end
            end
            if (id < nb) taken[id] = 1;
            sel.block_id = id[mtk_pkg::ID_W-1:0];
            sel.filler = fill;
            sel.last = (slot + 1 == k);
            pending_sel = {pending_sel, sel};
        end
        chain_len = 0;
    endtask

    // result checker and receiver backpressure
    always @(posedge aclk) begin
        selection_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_sel.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: id=%0d filler=%0b last=%0b",
                             m_block_id, m_filler, m_last_of_row);
            end else begin
                want = pending_sel.pop_front();
                if (m_block_id !== want.block_id || m_filler !== want.filler ||
                    m_last_of_row !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected id=%0d filler=%0b last=%0b,",
                                 want.block_id, want.filler, want.last,
                                 " got id=%0d filler=%0b last=%0b",
                                 m_block_id, m_filler, m_last_of_row);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(logic [23:0] qpos, logic [31:0] bits, logic row_end);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_query_pos <= qpos;
        s_score_bits <= bits;
        s_row_end <= row_end;
        do @(posedge aclk); while (!s_ready);
        predict_selection(qpos, bits, row_end);
        items_sent++;
        if (row_end) rows_sent++;
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (pending_sel.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(mtk_pkg::cfg_idx_t idx, int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[mtk_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        case (idx)
            mtk_pkg::CFG_NUM_BLOCKS:  num_blocks_r = value & 9'h1FF;
            mtk_pkg::CFG_K_SELECT:    k_select_r = value & 5'h1F;
            mtk_pkg::CFG_BLOCK_SIZE:  block_size_r = value & 16'hFFFF;
            mtk_pkg::CFG_CAUSAL:      causal_r = value & 1;
            mtk_pkg::CFG_FORCE_LOCAL: force_local_r = value & 1;
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned nb, int unsigned k, int unsigned bs,
                             int unsigned cz, int unsigned fl);
        hold_until_drained();
        write_reg(mtk_pkg::CFG_NUM_BLOCKS, nb);
        write_reg(mtk_pkg::CFG_K_SELECT, k);
        write_reg(mtk_pkg::CFG_BLOCK_SIZE, bs);
        write_reg(mtk_pkg::CFG_CAUSAL, cz);
        write_reg(mtk_pkg::CFG_FORCE_LOCAL, fl);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_score();
        case ($urandom_range(9))
            0: return POS_INF;
            1: return NEG_INF;
            2: return QNAN | $urandom_range(32'h3F_FFFF) | {1'($urandom_range(1)), 31'd0};
            3: return $urandom_range(1) ? NEG_ZERO : 32'd0;
            4: return $urandom_range(1) ? ONE : 32'hBF80_0000;
            5: return 32'h7F80_0001 + $urandom_range(32'h7F_FFFE);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_row(logic [23:0] qpos, int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(qpos, pick_score(), i + 1 == len);
    endtask

    task automatic send_scores(logic [23:0] qpos, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c);
        send_item(qpos, a, 1'b0);
        send_item(qpos, b, 1'b0);
        send_item(qpos, c, 1'b1);
    endtask

    task automatic test_special_scores();
        configure(4, 4, 1, 0, 0);
        send_scores(24'd0, NEG_INF, QNAN, NEG_ZERO);
        send_scores(24'd0, 32'd0, NEG_ZERO, POS_INF);
        send_scores(24'hFF_FFFF, QNAN, 32'hFFFF_FFFF, QNAN);
        configure(4, 3, 1, 1, 1);
        send_scores(24'd1, ONE, ONE, ONE);
        send_scores(24'd2, NEG_INF, NEG_INF, NEG_INF);
    endtask

    task automatic test_register_extremes();
        configure(0, 31, 0, 1, 1);
        send_row(24'hFF_FFFF, 1);
        configure(511, 0, 65535, 0, 0);
        send_row(24'hFF_FFFF, 2);
        configure(1, 16, 0, 0, 1);
        send_row(24'd0, 3);
        configure(256, 16, 64, 1, 1);
        send_row(24'd200, 5);
    endtask

    task automatic test_row_lengths();
        configure(3, 5, 1, 0, 0);
        send_row(24'd1, 6);
        configure(8, 6, 2, 1, 0);
        send_row(24'd9, 2);
    endtask

    task automatic test_random_rows(int gap_pct, int stall_pct, int n_items);
        int unsigned nb, len, bs, stop;
        logic [23:0] qpos;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            case ($urandom_range(3))
                0: nb = 1;
                1: nb = 256;
                default: nb = $urandom_range(2, 20);
            endcase
            case ($urandom_range(4))
                0: bs = 0;
                1: bs = 65535;
                default: bs = $urandom_range(1, 8);
            endcase
            configure(nb, $urandom_range(4) == 0 ? $urandom_range(31) : $urandom_range(16),
                      bs, $urandom_range(1), $urandom_range(1));
            repeat ($urandom_range(2, 4)) begin
                if (items_sent >= stop) break;
                len = $urandom_range(1, (nb < 20) ? nb + 2 : 20);
                qpos = ($urandom_range(3) == 0) ? 24'($urandom())
                                                : 24'($urandom_range(len * (bs + 1)));
                send_row(qpos, len);
            end
        end
    endtask

    initial begin
        num_blocks_r = 256;
        k_select_r = 16;
        block_size_r = 64;
        causal_r = 1;
        force_local_r = 1;
        chain_len = 0;
        local_blk = 0;
        blk_count = 0;
        row_open = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_scores();
        test_register_extremes();
        test_row_lengths();
        test_random_rows(18, 71, 25);
        test_random_rows(71, 18, 25);
        test_random_rows(0, 0, 25);
        hold_until_drained();
        $display("covered %0d score transfers in %0d rows, %0d selections checked",
                 items_sent, rows_sent, results_seen);
        $display("special scores, register extremes, short and long rows, random pressure");
        if (mismatches == 0 && pending_sel.size() == 0) begin
            $display("** masked_block_topk_select_core: PASSED **");
        end else begin
            $display("** masked_block_topk_select_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d selections outstanding", pending_sel.size());
        $display("** masked_block_topk_select_core: FAILED **");
        $finish;
    end

endmodule
